### hdl/assert_macros.svh
// Assertion macros used by the back stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### hdl/rdpd_pkg.sv
// Package with the shared types and constants of the rotary dial pulse decoder.
package rdpd_pkg;

  typedef enum logic [1:0] {
    PH_ONHOOK = 2'd0,
    PH_WAIT   = 2'd1,
    PH_DIAL   = 2'd2,
    PH_CONN   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_LEVEL_THRESHOLD  = 3'd0,
    REG_DEBOUNCE_MS      = 3'd1,
    REG_MIN_PULSE_MS     = 3'd2,
    REG_MAX_PULSE_MS     = 3'd3,
    REG_DIGIT_TIMEOUT_MS = 3'd4,
    REG_HANGUP_MS        = 3'd5,
    REG_PICKUP_GUARD_MS  = 3'd6,
    REG_UNUSED           = 3'd7
  } reg_idx_t;

  localparam logic [9:0]  LEVEL_THRESHOLD_RST  = 10'd310;
  localparam logic [15:0] DEBOUNCE_MS_RST      = 16'd20;
  localparam logic [15:0] MIN_PULSE_MS_RST     = 16'd40;
  localparam logic [15:0] MAX_PULSE_MS_RST     = 16'd100;
  localparam logic [15:0] DIGIT_TIMEOUT_MS_RST = 16'd300;
  localparam logic [15:0] HANGUP_MS_RST        = 16'd300;
  localparam logic [15:0] PICKUP_GUARD_MS_RST  = 16'd500;

  localparam logic [7:0] PULSE_MAX = 8'd255;

  typedef struct packed {
    logic [9:0]  level_threshold;
    logic [15:0] debounce_ms;
    logic [15:0] min_pulse_ms;
    logic [15:0] max_pulse_ms;
    logic [15:0] digit_timeout_ms;
    logic [15:0] hangup_ms;
    logic [15:0] pickup_guard_ms;
  } cfg_t;

  typedef struct packed {
    logic       above;
    logic       below;
    logic [7:0] elapsed;
  } item_t;

endpackage

### hdl/rotary_dial_pulse_decoder.sv
// Top level of the rotary dial pulse decoder.
// Requests enter on the in channel (in_valid/in_ready) with one ADC sample and the
// milliseconds elapsed since the previous sample. Each request yields exactly one
// result on the out channel (out_valid/out_ready): the debounced level, the phase,
// a digit flag and the current pulse count.
// A front stage registers the threshold comparison, a two-entry queue follows, and
// the back stage updates all timing state and fills the output register.
// A result passes the front register, the queue and the output register before out_valid.
// Throughput is one request per cycle while the receiver is ready, as the back stage updates all state per request.
// When the receiver stalls, the output register holds its result, the queue fills,
// and in_ready drops once the front stage and queue are full; nothing is lost.
// Reset (rst, synchronous) clears the millisecond clock, all stamps, the phase
// (on hook) and the pulse count, and loads the register defaults.
// Registers lie at byte address 4*i on the APB port; pready is always high.
module rotary_dial_pulse_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  sample,
  input  logic [7:0]  elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        level_confirmed,
  output logic [1:0]  phase,
  output logic        digit_valid,
  output logic [7:0]  digit_pulses
);

  rdpd_pkg::cfg_t  cfg;
  rdpd_pkg::item_t f_item, q_item;
  logic            f_valid, f_ready, q_valid, q_ready;

  rdpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .level_threshold (cfg.level_threshold),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .elapsed_ms      (elapsed_ms),
    .item_valid      (f_valid),
    .item_ready      (f_ready),
    .item            (f_item)
  );

  rdpd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  rdpd_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_valid      (q_valid),
    .item_ready      (q_ready),
    .item            (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .level_confirmed (level_confirmed),
    .phase           (phase),
    .digit_valid     (digit_valid),
    .digit_pulses    (digit_pulses)
  );

endmodule

### hdl/rdpd_regs.sv
// APB configuration registers of the rotary dial pulse decoder.
module rdpd_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rdpd_pkg::cfg_t      cfg
);

  rdpd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = rdpd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold  <= rdpd_pkg::LEVEL_THRESHOLD_RST;
      cfg.debounce_ms      <= rdpd_pkg::DEBOUNCE_MS_RST;
      cfg.min_pulse_ms     <= rdpd_pkg::MIN_PULSE_MS_RST;
      cfg.max_pulse_ms     <= rdpd_pkg::MAX_PULSE_MS_RST;
      cfg.digit_timeout_ms <= rdpd_pkg::DIGIT_TIMEOUT_MS_RST;
      cfg.hangup_ms        <= rdpd_pkg::HANGUP_MS_RST;
      cfg.pickup_guard_ms  <= rdpd_pkg::PICKUP_GUARD_MS_RST;
    end else if (wr_en) begin
      unique case (idx)
        rdpd_pkg::REG_LEVEL_THRESHOLD:  cfg.level_threshold  <= pwdata[9:0];
        rdpd_pkg::REG_DEBOUNCE_MS:      cfg.debounce_ms      <= pwdata[15:0];
        rdpd_pkg::REG_MIN_PULSE_MS:     cfg.min_pulse_ms     <= pwdata[15:0];
        rdpd_pkg::REG_MAX_PULSE_MS:     cfg.max_pulse_ms     <= pwdata[15:0];
        rdpd_pkg::REG_DIGIT_TIMEOUT_MS: cfg.digit_timeout_ms <= pwdata[15:0];
        rdpd_pkg::REG_HANGUP_MS:        cfg.hangup_ms        <= pwdata[15:0];
        rdpd_pkg::REG_PICKUP_GUARD_MS:  cfg.pickup_guard_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rdpd_pkg::REG_LEVEL_THRESHOLD:  prdata = {22'd0, cfg.level_threshold};
      rdpd_pkg::REG_DEBOUNCE_MS:      prdata = {16'd0, cfg.debounce_ms};
      rdpd_pkg::REG_MIN_PULSE_MS:     prdata = {16'd0, cfg.min_pulse_ms};
      rdpd_pkg::REG_MAX_PULSE_MS:     prdata = {16'd0, cfg.max_pulse_ms};
      rdpd_pkg::REG_DIGIT_TIMEOUT_MS: prdata = {16'd0, cfg.digit_timeout_ms};
      rdpd_pkg::REG_HANGUP_MS:        prdata = {16'd0, cfg.hangup_ms};
      rdpd_pkg::REG_PICKUP_GUARD_MS:  prdata = {16'd0, cfg.pickup_guard_ms};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

### hdl/rdpd_front.sv
// Front stage: accepts samples and classifies them against the threshold.
module rdpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [9:0]          level_threshold,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          sample,
  input  logic [7:0]          elapsed_ms,
  output logic                item_valid,
  input  logic                item_ready,
  output rdpd_pkg::item_t     item
);

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.above   <= sample > level_threshold;
      item.below   <= sample < level_threshold;
      item.elapsed <= elapsed_ms;
    end
  end

endmodule

### hdl/rdpd_fifo.sv
// Two-entry queue between the front and back stages.
module rdpd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  rdpd_pkg::item_t     push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rdpd_pkg::item_t     pop_item
);

  localparam int DEPTH = 2;

  rdpd_pkg::item_t entries [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push_ready = count != 2'(DEPTH);
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### hdl/rdpd_back.sv
// Back stage: millisecond clock, debounce, phase machine and pulse counting.
`include "assert_macros.svh"
module rdpd_back #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rdpd_pkg::cfg_t      cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  rdpd_pkg::item_t     item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                level_confirmed,
  output logic [1:0]          phase,
  output logic                digit_valid,
  output logic [7:0]          digit_pulses
);

  logic [TIME_BITS-1:0] clock_ms, rise_stamp, fall_stamp, pickup_stamp;
  logic                 raw_high, confirmed_high, pulse_taken;
  rdpd_pkg::phase_t     cur_phase;
  logic [7:0]           pulse_count;

  logic [TIME_BITS-1:0] clock_next, rise_next, fall_next, pickup_next;
  logic                 raw_next, conf_next, taken_next, digit_next;
  rdpd_pkg::phase_t     phase_pre, phase_next;
  logic [7:0]           count_next;

  logic [TIME_BITS-1:0] since_rise, since_fall, since_pickup, pulse_len;
  logic [TIME_BITS-1:0] deb_w, hang_w, guard_w, min_w, max_w, tmo_w;
  logic                 raw_mid, conf_mid, pulse_ok, guard_done, digit_done;
  logic                 step;

  assign item_ready = !out_valid || out_ready;
  assign step       = item_valid && item_ready;

  assign deb_w   = TIME_BITS'(cfg.debounce_ms);
  assign hang_w  = TIME_BITS'(cfg.hangup_ms);
  assign guard_w = TIME_BITS'(cfg.pickup_guard_ms);
  assign min_w   = TIME_BITS'(cfg.min_pulse_ms);
  assign max_w   = TIME_BITS'(cfg.max_pulse_ms);
  assign tmo_w   = TIME_BITS'(cfg.digit_timeout_ms);

  always_comb begin
    clock_next = clock_ms + TIME_BITS'(item.elapsed);
    rise_next  = rise_stamp;
    fall_next  = fall_stamp;
    raw_mid    = raw_high;
    if (item.above && !raw_high) begin
      rise_next = clock_next;
      raw_mid   = 1'b1;
    end
    raw_next = raw_mid;
    if (item.below && raw_mid) begin
      fall_next = clock_next;
      raw_next  = 1'b0;
    end
    since_rise   = clock_next - rise_next;
    since_fall   = clock_next - fall_next;
    since_pickup = clock_next - pickup_stamp;
    pulse_len    = fall_next - rise_next;
    conf_mid = confirmed_high;
    if (raw_next && since_rise > deb_w) begin
      conf_mid = 1'b1;
    end
    conf_next = conf_mid;
    if (!raw_next && since_fall > deb_w) begin
      conf_next = 1'b0;
    end
    phase_pre  = (conf_next && since_rise > hang_w) ? rdpd_pkg::PH_ONHOOK : cur_phase;
    guard_done = since_pickup > guard_w && conf_next;
    pulse_ok   = pulse_len >= min_w && pulse_len <= max_w;
  end

  always_comb begin
    taken_next  = pulse_taken;
    count_next  = pulse_count;
    pickup_next = pickup_stamp;
    unique case (phase_pre)
      rdpd_pkg::PH_ONHOOK: begin
        if (!conf_next) begin
          pickup_next = clock_next;
        end
      end
      rdpd_pkg::PH_WAIT: begin
        count_next = 8'd0;
      end
      rdpd_pkg::PH_DIAL: begin
        if (conf_next) begin
          taken_next = 1'b0;
        end
        if (!taken_next && !conf_next && pulse_ok) begin
          taken_next = 1'b1;
          if (pulse_count != rdpd_pkg::PULSE_MAX) begin
            count_next = pulse_count + 8'd1;
          end
        end
      end
      default: ;
    endcase
    digit_done = phase_pre == rdpd_pkg::PH_DIAL && since_fall >= tmo_w && count_next != 8'd0;
    digit_next = digit_done;
  end

  always_comb begin
    phase_next = phase_pre;
    unique case (phase_pre)
      rdpd_pkg::PH_ONHOOK: if (!conf_next) phase_next = rdpd_pkg::PH_WAIT;
      rdpd_pkg::PH_WAIT:   if (guard_done) phase_next = rdpd_pkg::PH_DIAL;
      rdpd_pkg::PH_DIAL:   if (digit_done) phase_next = rdpd_pkg::PH_CONN;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms       <= '0;
      rise_stamp     <= '0;
      fall_stamp     <= '0;
      pickup_stamp   <= '0;
      raw_high       <= 1'b0;
      confirmed_high <= 1'b0;
      pulse_taken    <= 1'b0;
      cur_phase      <= rdpd_pkg::PH_ONHOOK;
      pulse_count    <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (step) begin
        clock_ms       <= clock_next;
        rise_stamp     <= rise_next;
        fall_stamp     <= fall_next;
        pickup_stamp   <= pickup_next;
        raw_high       <= raw_next;
        confirmed_high <= conf_next;
        pulse_taken    <= taken_next;
        cur_phase      <= phase_next;
        pulse_count    <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      level_confirmed <= conf_next;
      phase           <= phase_next;
      digit_valid     <= digit_next;
      digit_pulses    <= count_next;
    end
  end

  `ASSERT_CLK(a_digit_ends_dial, clk, rst, (out_valid && digit_valid) |-> (phase == rdpd_pkg::PH_CONN && digit_pulses != 8'd0), "digit reported outside a finished dial")
  `ASSERT_CLK(a_out_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(digit_pulses)), "result changed while the receiver stalled")
  `ASSERT_CLK(a_clock_holds, clk, rst, !step |=> $stable(clock_ms), "clock moved without a request")

endmodule

### tb/sv/tb_rotary_dial_pulse_decoder.sv
// Self-checking testbench for the rotary dial pulse decoder with a built-in call-progress predictor.
`timescale 1ns / 1ps

module tb_rotary_dial_pulse_decoder;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DIR_N = 24;
  localparam int PHASE_ITEMS = 100;
  localparam int SAT_PULSES = 256;

  typedef struct packed {
    logic [9:0] sample;
    logic [7:0] elapsed;
  } line_req_t;

  typedef struct packed {
    logic              level;
    rdpd_pkg::phase_t  ph;
    logic              digit;
    logic [7:0]        pulses;
  } line_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  sample = '0;
  logic [7:0]  elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        level_confirmed;
  logic [1:0]  phase;
  logic        digit_valid;
  logic [7:0]  digit_pulses;

  // Register mirror.
  logic [9:0]  cfg_thr;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_pmin;
  logic [15:0] cfg_pmax;
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_hangup;
  logic [15:0] cfg_guard;

  // Line state as the decoder should hold it.
  logic [31:0]      now_ms;
  logic [31:0]      rise_ms;
  logic [31:0]      fall_ms;
  logic [31:0]      pickup_ms;
  logic             raw_hi;
  logic             conf_hi;
  logic             pulse_done;
  rdpd_pkg::phase_t call_phase;
  logic [7:0]       pulse_cnt;

  line_req_t pending_reqs[$];
  line_res_t expected_results[$];
  line_res_t want_res;
  int        errors = 0;
  int        cycle_cnt = 0;
  int        step_ms = 4;
  bit        quiet = 1'b0;

  logic [17:0] directed_reqs [DIR_N] = '{
    {10'd0, 8'd0}, {10'd0, 8'd255}, {10'd0, 8'd255}, {10'd1023, 8'd30},
    {10'd310, 8'd255}, {10'd0, 8'd1}, {10'd0, 8'd21}, {10'd1023, 8'd1},
    {10'd1023, 8'd25}, {10'd1022, 8'd30}, {10'd309, 8'd1}, {10'd1, 8'd25},
    {10'd0, 8'd255}, {10'd0, 8'd100}, {10'd1023, 8'd0}, {10'd1023, 8'd255},
    {10'd1023, 8'd128}, {10'd0, 8'd0}, {10'd0, 8'd21}, {10'h2AA, 8'hAA},
    {10'h155, 8'h55}, {10'd311, 8'd1}, {10'd310, 8'd0}, {10'd309, 8'd1}
  };

  rotary_dial_pulse_decoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .elapsed_ms      (elapsed_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .level_confirmed (level_confirmed),
    .phase           (phase),
    .digit_valid     (digit_valid),
    .digit_pulses    (digit_pulses)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic line_res_t decode_sample(line_req_t r);
    line_res_t res;
    logic [31:0] len;
    res.digit = 1'b0;
    now_ms = now_ms + 32'(r.elapsed);
    if (r.sample > cfg_thr && !raw_hi) begin
      rise_ms = now_ms;
      raw_hi = 1'b1;
    end
    if (r.sample < cfg_thr && raw_hi) begin
      fall_ms = now_ms;
      raw_hi = 1'b0;
    end
    if (raw_hi && (now_ms - rise_ms) > 32'(cfg_debounce)) conf_hi = 1'b1;
    if (!raw_hi && (now_ms - fall_ms) > 32'(cfg_debounce)) conf_hi = 1'b0;
    if (conf_hi && (now_ms - rise_ms) > 32'(cfg_hangup)) call_phase = rdpd_pkg::PH_ONHOOK;
    case (call_phase)
      rdpd_pkg::PH_ONHOOK: begin
        if (!conf_hi) begin
          call_phase = rdpd_pkg::PH_WAIT;
          pickup_ms = now_ms;
        end
      end
      rdpd_pkg::PH_WAIT: begin
        pulse_cnt = '0;
        if ((now_ms - pickup_ms) > 32'(cfg_guard) && conf_hi) begin
          call_phase = rdpd_pkg::PH_DIAL;
        end
      end
      rdpd_pkg::PH_DIAL: begin
        if (conf_hi) pulse_done = 1'b0;
        if (!pulse_done && !conf_hi) begin
          len = fall_ms - rise_ms;
          if (len >= 32'(cfg_pmin) && len <= 32'(cfg_pmax)) begin
            pulse_done = 1'b1;
            if (pulse_cnt != rdpd_pkg::PULSE_MAX) pulse_cnt = pulse_cnt + 8'd1;
          end
        end
        if ((now_ms - fall_ms) >= 32'(cfg_timeout) && pulse_cnt != 8'd0) begin
          call_phase = rdpd_pkg::PH_CONN;
          res.digit = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.level = conf_hi;
    res.ph = call_phase;
    res.pulses = pulse_cnt;
    return res;
  endfunction

  // Request driver: predicts on acceptance, then loads the next pending request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(decode_sample({sample, elapsed_ms}));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          {sample, elapsed_ms} <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 7);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: no request outstanding");
          errors++;
        end else begin
          want_res = expected_results.pop_front();
          if (level_confirmed !== want_res.level) begin
            $error("level_confirmed: expected %0d, got %0d", want_res.level, level_confirmed);
            errors++;
          end
          if (phase !== want_res.ph) begin
            $error("phase: expected %0d, got %0d", want_res.ph, phase);
            errors++;
          end
          if (digit_valid !== want_res.digit) begin
            $error("digit_valid: expected %0d, got %0d", want_res.digit, digit_valid);
            errors++;
          end
          if (digit_pulses !== want_res.pulses) begin
            $error("digit_pulses: expected %0d, got %0d", want_res.pulses, digit_pulses);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic set_reg(rdpd_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rdpd_pkg::REG_LEVEL_THRESHOLD: cfg_thr = value[9:0];
      rdpd_pkg::REG_DEBOUNCE_MS: cfg_debounce = value[15:0];
      rdpd_pkg::REG_MIN_PULSE_MS: cfg_pmin = value[15:0];
      rdpd_pkg::REG_MAX_PULSE_MS: cfg_pmax = value[15:0];
      rdpd_pkg::REG_DIGIT_TIMEOUT_MS: cfg_timeout = value[15:0];
      rdpd_pkg::REG_HANGUP_MS: cfg_hangup = value[15:0];
      rdpd_pkg::REG_PICKUP_GUARD_MS: cfg_guard = value[15:0];
      default: begin
      end
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx != rdpd_pkg::REG_UNUSED && prdata !== value) begin
      $error("%s: expected %0d, got %0d", idx.name(), value, prdata);
      errors++;
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_req(logic [9:0] s, logic [7:0] e);
    pending_reqs.push_back({s, e});
  endfunction

  function automatic logic [9:0] level_sample(bit hi);
    if ($urandom_range(24) == 0) return cfg_thr;
    if (hi) return 10'($urandom_range(1023, int'(cfg_thr) + 1));
    return 10'($urandom_range(int'(cfg_thr) - 1, 0));
  endfunction

  task automatic hold_line(bit hi, int ms);
    int left;
    int e;
    left = ms;
    while (left > 0) begin
      e = ($urandom_range(19) == 0) ? 0 : $urandom_range(step_ms, 1);
      if (e > left) e = left;
      push_req(level_sample(hi), 8'(e));
      left -= e;
    end
  endtask

  task automatic noise_burst(int emax);
    logic [9:0] s;
    repeat ($urandom_range(12, 3)) begin
      case ($urandom_range(3))
        0: s = '0;
        1: s = '1;
        2: s = cfg_thr;
        default: s = 10'($urandom);
      endcase
      push_req(s, 8'($urandom_range(emax, 0)));
    end
  endtask

  // Pickup, one digit of pulses, the quiet time that ends it, at times a stray pulse, then hang-up.
  task automatic dial_call();
    hold_line(1'b0, cfg_guard + $urandom_range(40, 5));
    repeat ($urandom_range(10, 1)) begin
      if ($urandom_range(4) == 0) begin
        hold_line(1'b1, $urandom_range(int'(cfg_pmax) + 30, cfg_debounce + step_ms + 1));
      end else begin
        hold_line(1'b1, $urandom_range(cfg_pmax, cfg_pmin));
      end
      hold_line(1'b0, cfg_debounce + step_ms + $urandom_range(20, 2));
    end
    hold_line(1'b0, cfg_timeout + $urandom_range(30, 0));
    if ($urandom_range(2) == 0) begin
      hold_line(1'b1, cfg_pmin);
      hold_line(1'b0, cfg_debounce + step_ms + 2);
    end
    hold_line(1'b1, cfg_hangup + cfg_debounce + $urandom_range(40, 5));
  endtask

  task automatic random_traffic();
    int deb;
    int pmin;
    int pmax;
    step_ms = $urandom_range(6, 3);
    deb = $urandom_range(15, 0);
    pmin = deb + step_ms + $urandom_range(20, 2);
    pmax = pmin + $urandom_range(40, 0);
    set_reg(rdpd_pkg::REG_LEVEL_THRESHOLD, $urandom_range(1000, 20));
    set_reg(rdpd_pkg::REG_DEBOUNCE_MS, deb);
    set_reg(rdpd_pkg::REG_MIN_PULSE_MS, pmin);
    set_reg(rdpd_pkg::REG_MAX_PULSE_MS, pmax);
    set_reg(rdpd_pkg::REG_DIGIT_TIMEOUT_MS, pmax + 2 * step_ms + $urandom_range(150, 20));
    set_reg(rdpd_pkg::REG_HANGUP_MS, pmax + deb + 2 * step_ms + $urandom_range(150, 20));
    set_reg(rdpd_pkg::REG_PICKUP_GUARD_MS, $urandom_range(200, 0));
    while (pending_reqs.size() < PHASE_ITEMS) begin
      if ($urandom_range(9) < 8) begin
        dial_call();
      end else begin
        noise_burst($urandom_range(1) ? 255 : 8);
      end
    end
    drain();
  endtask

  initial begin
    cfg_thr = rdpd_pkg::LEVEL_THRESHOLD_RST;
    cfg_debounce = rdpd_pkg::DEBOUNCE_MS_RST;
    cfg_pmin = rdpd_pkg::MIN_PULSE_MS_RST;
    cfg_pmax = rdpd_pkg::MAX_PULSE_MS_RST;
    cfg_timeout = rdpd_pkg::DIGIT_TIMEOUT_MS_RST;
    cfg_hangup = rdpd_pkg::HANGUP_MS_RST;
    cfg_guard = rdpd_pkg::PICKUP_GUARD_MS_RST;
    now_ms = '0;
    rise_ms = '0;
    fall_ms = '0;
    pickup_ms = '0;
    raw_hi = 1'b0;
    conf_hi = 1'b0;
    pulse_done = 1'b0;
    call_phase = rdpd_pkg::PH_ONHOOK;
    pulse_cnt = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_reqs[i]) pending_reqs.push_back(directed_reqs[i]);
    drain();

    random_traffic();

    // Every register at zero, plus a write to the unused address.
    set_reg(rdpd_pkg::REG_LEVEL_THRESHOLD, 0);
    set_reg(rdpd_pkg::REG_DEBOUNCE_MS, 0);
    set_reg(rdpd_pkg::REG_MIN_PULSE_MS, 0);
    set_reg(rdpd_pkg::REG_MAX_PULSE_MS, 0);
    set_reg(rdpd_pkg::REG_DIGIT_TIMEOUT_MS, 0);
    set_reg(rdpd_pkg::REG_HANGUP_MS, 0);
    set_reg(rdpd_pkg::REG_PICKUP_GUARD_MS, 0);
    set_reg(rdpd_pkg::REG_UNUSED, 32'h5A5);
    repeat (2) noise_burst(3);
    repeat (2) noise_burst(255);
    drain();

    // Saturate the pulse count with the shortest pulses the debounce allows.
    quiet = 1'b1;
    set_reg(rdpd_pkg::REG_LEVEL_THRESHOLD, 512);
    set_reg(rdpd_pkg::REG_MIN_PULSE_MS, 0);
    set_reg(rdpd_pkg::REG_MAX_PULSE_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_DIGIT_TIMEOUT_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_HANGUP_MS, 0);
    repeat (3) push_req(10'd1023, 8'd1);
    drain();
    set_reg(rdpd_pkg::REG_HANGUP_MS, 16'hFFFF);
    repeat (2) push_req(10'($urandom_range(511, 0)), 8'd1);
    repeat (2) push_req(10'($urandom_range(1023, 513)), 8'd1);
    repeat (SAT_PULSES) begin
      repeat (2) push_req(10'($urandom_range(511, 0)), 8'd1);
      repeat (2) push_req(10'($urandom_range(1023, 513)), 8'd1);
    end
    drain();
    quiet = 1'b0;

    set_reg(rdpd_pkg::REG_LEVEL_THRESHOLD, 1023);
    set_reg(rdpd_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_MIN_PULSE_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_MAX_PULSE_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_DIGIT_TIMEOUT_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_HANGUP_MS, 16'hFFFF);
    set_reg(rdpd_pkg::REG_PICKUP_GUARD_MS, 16'hFFFF);
    repeat (4) noise_burst(255);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
